[rtl/lss_pkg.sv]
// ============================================================================
// lss_pkg : shared types and constants of the linear state-space step block
// Field widths, fixed-point constants, matrix select codes and the
// command/status bundles between controller and datapath.
// ============================================================================
package lss_pkg;

    localparam int DATA_W = 32;              // signed Q16.16
    localparam int FRAC_W = 16;
    localparam int DT_W   = 31;              // unsigned Q15.16 time step
    localparam int SEL_W  = 2;
    localparam int RC_W   = 3;
    localparam int YIDX_W = 2;
    localparam int MUL_W  = DATA_W + 1;      // room for the unsigned time step
    localparam int PROD_W = 2 * DATA_W - FRAC_W;

    localparam int STATES_DEF  = 4;
    localparam int INPUTS_DEF  = 2;
    localparam int OUTPUTS_DEF = 2;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_STEP = 1'b1;

    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

    typedef enum logic [SEL_W-1:0] {
        MAT_A = 2'd0,
        MAT_B = 2'd1,
        MAT_C = 2'd2,
        MAT_D = 2'd3
    } t_mat_sel;

    // controller -> datapath
    typedef struct packed {
        logic load;     // write one coefficient now
        logic start;    // capture u and dt of a new step
        logic issue;    // push one multiply into the pipeline
        logic upd;      // the pushed multiply is a state update
        logic first;    // first product of a dot product
        logic last;     // last product of a dot product
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic stall;    // output register held while a result waits, pipeline frozen
        logic busy;     // pipeline holds work
    } t_dp_sts;

endpackage

[rtl/linear_state_space_step_top.sv]
// ============================================================================
// linear_state_space_step_top : discrete linear state-space model, Euler step
// Load requests write one coefficient of A, B, C or D; step requests compute
// y = C*x + D*u, emit it element by element, and advance x += (A*x+B*u)*dt.
// ============================================================================
//
//  Channel   Direction  Handshake                  Payload
//  --------  ---------  -------------------------  ----------------------------
//  in        in         i_in_valid / o_in_ready    req_type, matrix_sel, row,
//                                                  col, coef_value, u0..u3,
//                                                  step_dt
//  out       out        o_out_valid / i_out_ready  y_value, y_index, last
//
//  A load request leaves the input open. A step request closes the input
//  from its accept until the pipeline has drained: one product a cycle,
//  while the output does not stall the pipeline, through the single shared
//  multiply-accumulate over the [A B; C D] coefficient store, one update
//  product per state, then the three-stage pipeline drains.
//  Reset (synchronous, active low) zeroes the state and marks every
//  coefficient entry unwritten, which reads as zero; no clearing pass.
//  A held output result freezes the pipeline only when the next output
//  element is ready to leave; the last element may wait while new requests
//  are accepted.
//
module linear_state_space_step_top #(
    parameter int STATES    = lss_pkg::STATES_DEF,
    parameter int INPUTS_N  = lss_pkg::INPUTS_DEF,
    parameter int OUTPUTS_N = lss_pkg::OUTPUTS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // request channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_req_type,
    input  logic [lss_pkg::SEL_W-1:0]            i_matrix_sel,
    input  logic [lss_pkg::RC_W-1:0]             i_row,
    input  logic [lss_pkg::RC_W-1:0]             i_col,
    input  logic signed [lss_pkg::DATA_W-1:0]    i_coef_value,
    input  logic signed [lss_pkg::DATA_W-1:0]    i_u0,
    input  logic signed [lss_pkg::DATA_W-1:0]    i_u1,
    input  logic signed [lss_pkg::DATA_W-1:0]    i_u2,
    input  logic signed [lss_pkg::DATA_W-1:0]    i_u3,
    input  logic [lss_pkg::DT_W-1:0]             i_step_dt,
    // result channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [lss_pkg::DATA_W-1:0]    o_y_value,
    output logic [lss_pkg::YIDX_W-1:0]           o_y_index,
    output logic                                 o_last
);
    import lss_pkg::*;

    localparam int ROW_N = STATES + OUTPUTS_N;
    localparam int COL_N = STATES + INPUTS_N;
    localparam int A_W   = $clog2(ROW_N * COL_N);
    localparam int R_W   = $clog2(ROW_N);
    localparam int C_W   = $clog2(COL_N);

    t_dp_cmd        cmd;
    t_dp_sts        sts;
    logic [A_W-1:0] seq_addr;
    logic [R_W-1:0] seq_row;
    logic [C_W-1:0] seq_col;

    // Sequencer: accepts requests, walks the coefficient store, issues the
    // state updates, then waits for the pipeline to empty.
    lss_ctrl #(
        .STATES    (STATES),
        .INPUTS_N  (INPUTS_N),
        .OUTPUTS_N (OUTPUTS_N)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_addr     (seq_addr),
        .o_row      (seq_row),
        .o_col      (seq_col)
    );

    // Datapath: coefficient memory, state registers, shared multiply-
    // accumulate and the output register.
    lss_dp #(
        .STATES    (STATES),
        .INPUTS_N  (INPUTS_N),
        .OUTPUTS_N (OUTPUTS_N)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_addr       (seq_addr),
        .i_row        (seq_row),
        .i_col        (seq_col),
        .i_matrix_sel (i_matrix_sel),
        .i_wr_row     (i_row),
        .i_wr_col     (i_col),
        .i_coef_value (i_coef_value),
        .i_u0         (i_u0),
        .i_u1         (i_u1),
        .i_u2         (i_u2),
        .i_u3         (i_u3),
        .i_step_dt    (i_step_dt),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_y_value    (o_y_value),
        .o_y_index    (o_y_index),
        .o_last       (o_last)
    );

endmodule

[rtl/lss_ctrl.sv]
// ============================================================================
// lss_ctrl : sequencer of the linear state-space step block
// Walks the combined [A B; C D] coefficient store row by row, then issues
// the state updates and waits for the pipeline to drain.
// ============================================================================
module lss_ctrl #(
    parameter int STATES    = lss_pkg::STATES_DEF,
    parameter int INPUTS_N  = lss_pkg::INPUTS_DEF,
    parameter int OUTPUTS_N = lss_pkg::OUTPUTS_DEF,
    localparam int ROW_N = STATES + OUTPUTS_N,
    localparam int COL_N = STATES + INPUTS_N,
    localparam int DEPTH = ROW_N * COL_N,
    localparam int A_W   = $clog2(DEPTH),
    localparam int R_W   = $clog2(ROW_N),
    localparam int C_W   = $clog2(COL_N)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_req_type,
    output logic              o_in_ready,
    input  lss_pkg::t_dp_sts  i_sts,
    output lss_pkg::t_dp_cmd  o_cmd,
    output logic [A_W-1:0]    o_addr,
    output logic [R_W-1:0]    o_row,
    output logic [C_W-1:0]    o_col
);
    import lss_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MAC   = 4'b0010,
        ST_UPD   = 4'b0100,
        ST_DRAIN = 4'b1000
    } t_state;

    t_state         r_state, n_state;
    logic [A_W-1:0] r_addr, n_addr;
    logic [R_W-1:0] r_row, n_row;
    logic [C_W-1:0] r_col, n_col;
    logic           row_end;

    assign row_end = (r_col == C_W'(COL_N - 1));

    always_comb begin
        n_state    = r_state;
        n_addr     = r_addr;
        n_row      = r_row;
        n_col      = r_col;
        o_cmd      = '0;
        o_in_ready = (r_state == ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_req_type == REQ_STEP) begin
                        o_cmd.start = 1'b1;
                        n_state     = ST_MAC;
                        n_addr      = '0;
                        n_row       = '0;
                        n_col       = '0;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            ST_MAC: begin
                if (!i_sts.stall) begin
                    o_cmd.issue = 1'b1;
                    o_cmd.first = (r_col == '0);
                    o_cmd.last  = row_end;
                    n_addr      = r_addr + A_W'(1);
                    if (row_end) begin
                        n_col = '0;
                        n_row = r_row + R_W'(1);
                    end else begin
                        n_col = r_col + C_W'(1);
                    end
                    if (r_addr == A_W'(DEPTH - 1)) begin
                        n_state = ST_UPD;
                        n_row   = '0;
                    end
                end
            end
            ST_UPD: begin
                if (!i_sts.stall) begin
                    o_cmd.issue = 1'b1;
                    o_cmd.upd   = 1'b1;
                    o_cmd.first = 1'b1;
                    o_cmd.last  = 1'b1;
                    n_row       = r_row + R_W'(1);
                    if (r_row == R_W'(STATES - 1)) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (!i_sts.busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_addr  <= '0;
            r_row   <= '0;
            r_col   <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_row   <= n_row;
            r_col   <= n_col;
        end
    end

    assign o_addr = r_addr;
    assign o_row  = r_row;
    assign o_col  = r_col;

endmodule

[rtl/lss_dp.sv]
// ============================================================================
// lss_dp : datapath of the linear state-space step block
// Coefficient memory with per-entry valid bits, state and derivative
// registers, one shared multiply-accumulate pipeline and the output register.
// ============================================================================
module lss_dp #(
    parameter int STATES    = lss_pkg::STATES_DEF,
    parameter int INPUTS_N  = lss_pkg::INPUTS_DEF,
    parameter int OUTPUTS_N = lss_pkg::OUTPUTS_DEF,
    localparam int ROW_N = STATES + OUTPUTS_N,
    localparam int COL_N = STATES + INPUTS_N,
    localparam int DEPTH = ROW_N * COL_N,
    localparam int A_W   = $clog2(DEPTH),
    localparam int R_W   = $clog2(ROW_N),
    localparam int C_W   = $clog2(COL_N)
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  lss_pkg::t_dp_cmd                     i_cmd,
    output lss_pkg::t_dp_sts                     o_sts,
    input  logic [A_W-1:0]                       i_addr,
    input  logic [R_W-1:0]                       i_row,
    input  logic [C_W-1:0]                       i_col,
    input  logic [lss_pkg::SEL_W-1:0]            i_matrix_sel,
    input  logic [lss_pkg::RC_W-1:0]             i_wr_row,
    input  logic [lss_pkg::RC_W-1:0]             i_wr_col,
    input  logic signed [lss_pkg::DATA_W-1:0]    i_coef_value,
    input  logic signed [lss_pkg::DATA_W-1:0]    i_u0,
    input  logic signed [lss_pkg::DATA_W-1:0]    i_u1,
    input  logic signed [lss_pkg::DATA_W-1:0]    i_u2,
    input  logic signed [lss_pkg::DATA_W-1:0]    i_u3,
    input  logic [lss_pkg::DT_W-1:0]             i_step_dt,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [lss_pkg::DATA_W-1:0]    o_y_value,
    output logic [lss_pkg::YIDX_W-1:0]           o_y_index,
    output logic                                 o_last
);
    import lss_pkg::*;

    localparam int X_IW  = (STATES > 1) ? $clog2(STATES) : 1;
    localparam int U_IW  = (INPUTS_N > 1) ? $clog2(INPUTS_N) : 1;
    localparam int ACC_W = PROD_W + $clog2(COL_N) + 1;

    // storage
    logic [DATA_W-1:0]        r_mem [DEPTH];
    logic [DEPTH-1:0]         r_cval;
    logic signed [DATA_W-1:0] r_x  [STATES];
    logic signed [DATA_W-1:0] r_xd [STATES];
    logic signed [DATA_W-1:0] r_u  [INPUTS_N];
    logic [DT_W-1:0]          r_dt;
    logic signed [DATA_W-1:0] u_in [4];

    // coefficient write decode
    logic           wr_ok;
    logic [R_W-1:0] wr_r;
    logic [C_W-1:0] wr_c;
    logic [A_W-1:0] wr_addr;

    // pipeline
    logic                     en;
    logic [X_IW-1:0]          x_idx;
    logic [U_IW-1:0]          u_idx;
    logic signed [DATA_W-1:0] opnd;
    logic [DATA_W-1:0]        r_mem_q;
    logic                     r_cvld;
    logic                     r_s1_vld, r_s1_upd, r_s1_first, r_s1_last;
    logic [R_W-1:0]           r_s1_row;
    logic signed [DATA_W-1:0] r_s1_v;
    logic signed [DATA_W-1:0] xd_sel;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [2*MUL_W-1:0] mul_p;
    logic                     r_s2_vld, r_s2_upd, r_s2_first, r_s2_last;
    logic [R_W-1:0]           r_s2_row;
    logic signed [PROD_W-1:0] r_s2_prod;
    logic signed [DATA_W-1:0] r_s2_base;
    logic [ACC_W-1:0]         acc_base;
    logic                     r_s3_vld, r_s3_upd, r_s3_last;
    logic [R_W-1:0]           r_s3_row;
    logic [ACC_W-1:0]         r_acc;
    logic                     acc_ovf;
    logic signed [DATA_W-1:0] acc_sat;
    logic                     wb, wb_x_row, wb_y;

    // output register
    logic                     r_out_vld;
    logic signed [DATA_W-1:0] r_y_value;
    logic [YIDX_W-1:0]        r_y_index;
    logic                     r_last;

    assign u_in[0] = i_u0;
    assign u_in[1] = i_u1;
    assign u_in[2] = i_u2;
    assign u_in[3] = i_u3;

    // Map A, B, C, D onto one row-major [A B; C D] store.
    always_comb begin
        wr_ok = 1'b0;
        wr_r  = R_W'(i_wr_row);
        wr_c  = C_W'(i_wr_col);
        case (t_mat_sel'(i_matrix_sel))
            MAT_A: begin
                wr_ok = (32'(i_wr_row) < STATES) && (32'(i_wr_col) < STATES);
            end
            MAT_B: begin
                wr_ok = (32'(i_wr_row) < STATES) && (32'(i_wr_col) < INPUTS_N);
                wr_c  = C_W'(32'(i_wr_col) + STATES);
            end
            MAT_C: begin
                wr_ok = (32'(i_wr_row) < OUTPUTS_N) && (32'(i_wr_col) < STATES);
                wr_r  = R_W'(32'(i_wr_row) + STATES);
            end
            MAT_D: begin
                wr_ok = (32'(i_wr_row) < OUTPUTS_N) && (32'(i_wr_col) < INPUTS_N);
                wr_r  = R_W'(32'(i_wr_row) + STATES);
                wr_c  = C_W'(32'(i_wr_col) + STATES);
            end
            default: begin
                wr_ok = 1'b0;
            end
        endcase
        wr_addr = A_W'(32'(wr_r) * COL_N + 32'(wr_c));
    end

    // Freeze everything while an output result cannot leave and the next one waits.
    assign wb       = r_s3_vld && r_s3_last;
    assign wb_x_row = r_s3_row < R_W'(STATES);
    assign wb_y     = wb && !r_s3_upd && !wb_x_row;
    assign en       = !(wb_y && r_out_vld && !i_out_ready);

    assign o_sts.stall = !en;
    assign o_sts.busy  = r_s1_vld || r_s2_vld || r_s3_vld;

    // coefficient memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && wr_ok) begin
            r_mem[wr_addr] <= i_coef_value;
        end
        if (en && i_cmd.issue && !i_cmd.upd) begin
            r_mem_q <= r_mem[i_addr];
            r_cvld  <= r_cval[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cval <= '0;
        end else if (i_cmd.load && wr_ok) begin
            r_cval[wr_addr] <= 1'b1;
        end
    end

    // step operands
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            for (int j = 0; j < INPUTS_N; j++) begin
                r_u[j] <= u_in[j];
            end
            r_dt <= i_step_dt;
        end
    end

    // operand select: state for the first STATES columns and for updates, input after that
    assign x_idx = i_cmd.upd ? i_row[X_IW-1:0] : i_col[X_IW-1:0];
    assign u_idx = U_IW'(i_col - C_W'(STATES));

    always_comb begin
        if (i_cmd.upd || (i_col < C_W'(STATES))) begin
            opnd = r_x[x_idx];
        end else begin
            opnd = r_u[u_idx];
        end
    end

    // stage 1: operands
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= i_cmd.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_upd   <= i_cmd.upd;
            r_s1_first <= i_cmd.first;
            r_s1_last  <= i_cmd.last;
            r_s1_row   <= i_row;
            r_s1_v     <= opnd;
        end
    end

    // stage 2: product, truncated toward minus infinity
    // Read the derivative here, so a write-back at the issue edge is seen.
    assign xd_sel = r_xd[r_s1_row[X_IW-1:0]];

    always_comb begin
        if (r_s1_upd) begin
            mul_a = {xd_sel[DATA_W-1], xd_sel};
            mul_b = {2'b00, r_dt};
        end else begin
            mul_a = r_cvld ? {r_mem_q[DATA_W-1], r_mem_q} : '0;
            mul_b = {r_s1_v[DATA_W-1], r_s1_v};
        end
        mul_p = mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (en) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_upd   <= r_s1_upd;
            r_s2_first <= r_s1_first;
            r_s2_last  <= r_s1_last;
            r_s2_row   <= r_s1_row;
            r_s2_prod  <= mul_p[PROD_W+FRAC_W-1:FRAC_W];
            r_s2_base  <= r_s1_v;
        end
    end

    // stage 3: accumulate; a state update starts from the old state
    assign acc_base = r_s2_upd ? {{(ACC_W-DATA_W){r_s2_base[DATA_W-1]}}, r_s2_base} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (en) begin
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_upd  <= r_s2_upd;
            r_s3_last <= r_s2_last;
            r_s3_row  <= r_s2_row;
            if (r_s2_vld) begin
                r_acc <= (r_s2_first ? acc_base : r_acc)
                       + {{(ACC_W-PROD_W){r_s2_prod[PROD_W-1]}}, r_s2_prod};
            end
        end
    end

    // saturate to Q16.16
    assign acc_ovf = !((&r_acc[ACC_W-1:DATA_W-1]) || !(|r_acc[ACC_W-1:DATA_W-1]));
    assign acc_sat = acc_ovf ? (r_acc[ACC_W-1] ? Q_MIN : Q_MAX) : r_acc[DATA_W-1:0];

    // write back: state, derivative or output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < STATES; i++) begin
                r_x[i] <= '0;
            end
        end else if (en && wb && r_s3_upd) begin
            r_x[r_s3_row[X_IW-1:0]] <= acc_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && wb && !r_s3_upd && wb_x_row) begin
            r_xd[r_s3_row[X_IW-1:0]] <= acc_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en && wb_y) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && wb_y) begin
            r_y_value <= acc_sat;
            r_y_index <= YIDX_W'(r_s3_row - R_W'(STATES));
            r_last    <= (r_s3_row == R_W'(ROW_N - 1));
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_y_value   = r_y_value;
    assign o_y_index   = r_y_index;
    assign o_last      = r_last;

endmodule

[rtl/lss_chk.sv]
// ============================================================================
// lss_chk : port-level checks of the linear state-space step block
// Watches the top level's handshakes and output tagging over time.
// ============================================================================
module lss_chk #(
    parameter int OUTPUTS_N = lss_pkg::OUTPUTS_DEF
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic                        i_req_type,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [lss_pkg::YIDX_W-1:0]  o_y_index,
    input logic                        o_last
);
    import lss_pkg::*;

    // reset opens the input and empties the output
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready && !o_out_valid)
        else $error("lss_chk: state after reset wrong");

    // a step request closes the input once it is accepted
    a_step_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_req_type == REQ_STEP) |=> !o_in_ready)
        else $error("lss_chk: input open right after a step request");

    // last marks exactly the final output element
    a_last_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last == (o_y_index == YIDX_W'(OUTPUTS_N - 1))))
        else $error("lss_chk: last flag and element index disagree");

    // a held result keeps its tag
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_y_index)
                                        && $stable(o_last))
        else $error("lss_chk: stalled result changed");

endmodule

bind linear_state_space_step_top lss_chk #(.OUTPUTS_N(OUTPUTS_N)) u_lss_chk (.*);

[test/tb_top.sv]
// ============================================================================
// tb_top : self-checking bench for the linear state-space step block
// Drives load and step requests through the valid/ready request channel,
// predicts each output element with the bench's bit-accurate Q16.16 Euler
// step model or a value typed in the directed table, and compares each as it
// leaves. A short directed table opens the run; 1500 random requests follow,
// with random gaps on the request side and random stalls on the output side.
// ============================================================================
module tb_top;
    import lss_pkg::*;

    localparam int N_X = STATES_DEF;
    localparam int N_U = INPUTS_DEF;
    localparam int N_Y = OUTPUTS_DEF;

    localparam int RANDOM_REQUESTS = 1500;
    localparam int STUCK_LIMIT     = 2000;   // cycles with no handshake at all
    localparam int TAIL_CYCLES     = 60;     // more than one full step

    localparam logic signed [DATA_W-1:0] ZERO = 32'sd0;
    localparam logic signed [DATA_W-1:0] ONE  = 32'sh0001_0000;
    localparam logic signed [DATA_W-1:0] HALF = 32'sh0000_8000;
    localparam logic signed [DATA_W-1:0] M1   = -32'sd1;
    localparam logic [DT_W-1:0] DT_ZERO = 31'd0;
    localparam logic [DT_W-1:0] DT_ONE  = 31'h0001_0000;
    localparam logic [DT_W-1:0] DT_HALF = 31'h0000_8000;
    localparam logic [DT_W-1:0] DT_MAX  = 31'h7fff_ffff;
    localparam logic TYPED = 1'b1;   // expected outputs written in the table
    localparam logic PRED  = 1'b0;   // expected outputs from the predictor

    typedef struct packed {
        logic                      req_type;
        t_mat_sel                  sel;
        logic [RC_W-1:0]           row;
        logic [RC_W-1:0]           col;
        logic signed [DATA_W-1:0]  coef;
        logic signed [DATA_W-1:0]  u0;
        logic signed [DATA_W-1:0]  u1;
        logic signed [DATA_W-1:0]  u2;
        logic signed [DATA_W-1:0]  u3;
        logic [DT_W-1:0]           dt;
    } t_request;

    typedef struct packed {
        t_request                  rq;
        logic                      typed;
        logic signed [DATA_W-1:0]  y0;
        logic signed [DATA_W-1:0]  y1;
    } t_directed;

    typedef struct packed {
        logic signed [DATA_W-1:0]  value;
        logic [YIDX_W-1:0]         index;
        logic                      last;
    } t_y_elem;

    // Directed opening: zero state after reset, extremes, ignored writes
    // outside each matrix, saturation both ways, truncation of a negative
    // product, then a small system that drives the state into saturation.
    localparam int N_DIRECTED = 25;
    localparam t_directed DIRECTED_ROWS [N_DIRECTED] = '{
        '{'{REQ_STEP, MAT_A, 3'd0, 3'd0, ZERO, ZERO, ZERO, ZERO, ZERO, DT_ZERO},
          TYPED, ZERO, ZERO},
        '{'{REQ_STEP, MAT_A, 3'd0, 3'd0, ZERO, Q_MAX, Q_MIN, Q_MAX, Q_MIN, DT_MAX},
          TYPED, ZERO, ZERO},
        '{'{REQ_LOAD, MAT_A, 3'd7, 3'd7, Q_MAX, ZERO, ZERO, ZERO, ZERO, DT_ZERO},
          PRED, ZERO, ZERO},
        '{'{REQ_LOAD, MAT_B, 3'd0, 3'd2, Q_MAX, ZERO, ZERO, ZERO, ZERO, DT_ZERO},
          PRED, ZERO, ZERO},
        '{'{REQ_LOAD, MAT_C, 3'd2, 3'd0, Q_MAX, ZERO, ZERO, ZERO, ZERO, DT_ZERO},
          PRED, ZERO, ZERO},
        '{'{REQ_LOAD, MAT_D, 3'd0, 3'd7, Q_MAX, ZERO, ZERO, ZERO, ZERO, DT_ZERO},
          PRED, ZERO, ZERO},
        '{'{REQ_STEP, MAT_D, 3'd7, 3'd7, Q_MIN, Q_MAX, Q_MAX, Q_MIN, Q_MAX, DT_MAX},
          TYPED, ZERO, ZERO},
        '{'{REQ_LOAD, MAT_D, 3'd0, 3'd0, Q_MAX, ZERO, ZERO, ZERO, ZERO, DT_ZERO},
          PRED, ZERO, ZERO},
        '{'{REQ_STEP, MAT_A, 3'd0, 3'd0, ZERO, Q_MAX, ZERO, M1, ONE, DT_ONE},
          TYPED, Q_MAX, ZERO},
        '{'{REQ_STEP, MAT_A, 3'd0, 3'd0, ZERO, Q_MIN, ZERO, ONE, M1, DT_ONE},
          TYPED, Q_MIN, ZERO},
        '{'{REQ_LOAD, MAT_D, 3'd1, 3'd1, Q_MIN, ZERO, ZERO, ZERO, ZERO, DT_ZERO},
          PRED, ZERO, ZERO},
        '{'{REQ_STEP, MAT_A, 3'd0, 3'd0, ZERO, ZERO, Q_MIN, ZERO, ZERO, DT_HALF},
          TYPED, ZERO, Q_MAX},
        '{'{REQ_STEP, MAT_A, 3'd0, 3'd0, ZERO, ONE, M1, ZERO, ZERO, DT_ONE},
          PRED, ZERO, ZERO},
        '{'{REQ_LOAD, MAT_D, 3'd0, 3'd0, ONE, ZERO, ZERO, ZERO, ZERO, DT_ZERO},
          PRED, ZERO, ZERO},
        '{'{REQ_STEP, MAT_A, 3'd0, 3'd0, ZERO, M1, ZERO, ZERO, ZERO, DT_ONE},
          PRED, ZERO, ZERO},
        '{'{REQ_LOAD, MAT_A, 3'd0, 3'd0, -HALF, ZERO, ZERO, ZERO, ZERO, DT_ZERO},
          PRED, ZERO, ZERO},
        '{'{REQ_LOAD, MAT_B, 3'd0, 3'd0, ONE, ZERO, ZERO, ZERO, ZERO, DT_ZERO},
          PRED, ZERO, ZERO},
        '{'{REQ_LOAD, MAT_C, 3'd0, 3'd0, ONE, ZERO, ZERO, ZERO, ZERO, DT_ZERO},
          PRED, ZERO, ZERO},
        '{'{REQ_LOAD, MAT_A, 3'd3, 3'd3, Q_MIN, ZERO, ZERO, ZERO, ZERO, DT_ZERO},
          PRED, ZERO, ZERO},
        '{'{REQ_LOAD, MAT_B, 3'd3, 3'd1, Q_MAX, ZERO, ZERO, ZERO, ZERO, DT_ZERO},
          PRED, ZERO, ZERO},
        '{'{REQ_LOAD, MAT_C, 3'd1, 3'd3, Q_MAX, ZERO, ZERO, ZERO, ZERO, DT_ZERO},
          PRED, ZERO, ZERO},
        '{'{REQ_STEP, MAT_A, 3'd0, 3'd0, ZERO, ONE, ONE, ZERO, ZERO, DT_ONE},
          PRED, ZERO, ZERO},
        '{'{REQ_STEP, MAT_A, 3'd0, 3'd0, ZERO, -ONE, Q_MIN, ZERO, ZERO, DT_MAX},
          PRED, ZERO, ZERO},
        '{'{REQ_STEP, MAT_A, 3'd0, 3'd0, ZERO, ZERO, ZERO, ZERO, ZERO, DT_HALF},
          PRED, ZERO, ZERO},
        '{'{REQ_STEP, MAT_A, 3'd0, 3'd0, ZERO, HALF, -HALF, ZERO, ZERO, DT_ZERO},
          PRED, ZERO, ZERO}
    };

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_ready;
    logic                       i_req_type;
    logic [SEL_W-1:0]           i_matrix_sel;
    logic [RC_W-1:0]            i_row;
    logic [RC_W-1:0]            i_col;
    logic signed [DATA_W-1:0]   i_coef_value;
    logic signed [DATA_W-1:0]   i_u0;
    logic signed [DATA_W-1:0]   i_u1;
    logic signed [DATA_W-1:0]   i_u2;
    logic signed [DATA_W-1:0]   i_u3;
    logic [DT_W-1:0]            i_step_dt;
    logic                       o_out_valid;
    logic                       i_out_ready;
    logic signed [DATA_W-1:0]   o_y_value;
    logic [YIDX_W-1:0]          o_y_index;
    logic                       o_last;

    // Bench copy of the block's state and coefficient stores.
    logic signed [DATA_W-1:0]   x_state [N_X];
    logic signed [DATA_W-1:0]   mat_a [N_X*N_X];
    logic signed [DATA_W-1:0]   mat_b [N_X*N_U];
    logic signed [DATA_W-1:0]   mat_c [N_Y*N_X];
    logic signed [DATA_W-1:0]   mat_d [N_Y*N_U];

    t_y_elem pending_y [$];   // output elements still owed by the block
    t_y_elem want_y;

    int n_errors   = 0;
    int n_steps    = 0;
    int n_loads    = 0;
    int n_dropped  = 0;
    int n_checked  = 0;
    int stuck_cycles = 0;
    int out_stall  = 0;
    int cycle_cnt  = 0;

    always #6 i_clk = ~i_clk;

    linear_state_space_step_top #(
        .STATES    (N_X),
        .INPUTS_N  (N_U),
        .OUTPUTS_N (N_Y)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_req_type   (i_req_type),
        .i_matrix_sel (i_matrix_sel),
        .i_row        (i_row),
        .i_col        (i_col),
        .i_coef_value (i_coef_value),
        .i_u0         (i_u0),
        .i_u1         (i_u1),
        .i_u2         (i_u2),
        .i_u3         (i_u3),
        .i_step_dt    (i_step_dt),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_y_value    (o_y_value),
        .o_y_index    (o_y_index),
        .o_last       (o_last)
    );

    // Q16.16 product: exact, then an arithmetic shift, which floors.
    function automatic longint q_product(longint a, longint b);
        return (a * b) >>> FRAC_W;
    endfunction

    function automatic logic signed [DATA_W-1:0] clip32(longint v);
        if (v > longint'(Q_MAX)) return Q_MAX;
        if (v < longint'(Q_MIN)) return Q_MIN;
        return v[DATA_W-1:0];
    endfunction

    // Apply one accepted request to the bench state and queue the output
    // elements it owes. Typed table values replace the predicted values.
    function automatic void euler_step_predict(input t_request rq, input logic typed,
            input logic signed [DATA_W-1:0] typed_y0,
            input logic signed [DATA_W-1:0] typed_y1);
        logic signed [DATA_W-1:0] u_vec [4];
        logic signed [DATA_W-1:0] x_rate [N_X];
        longint acc;
        t_y_elem elem;
        if (rq.req_type == REQ_LOAD) begin
            n_loads++;
            // Drop writes that fall outside the selected matrix.
            case (rq.sel)
                MAT_A: if (rq.row < N_X && rq.col < N_X) mat_a[rq.row*N_X + rq.col] = rq.coef;
                       else n_dropped++;
                MAT_B: if (rq.row < N_X && rq.col < N_U) mat_b[rq.row*N_U + rq.col] = rq.coef;
                       else n_dropped++;
                MAT_C: if (rq.row < N_Y && rq.col < N_X) mat_c[rq.row*N_X + rq.col] = rq.coef;
                       else n_dropped++;
                default: if (rq.row < N_Y && rq.col < N_U) mat_d[rq.row*N_U + rq.col] = rq.coef;
                       else n_dropped++;
            endcase
            return;
        end
        n_steps++;
        u_vec = '{rq.u0, rq.u1, rq.u2, rq.u3};
        for (int i = 0; i < N_X; i++) begin
            acc = 0;
            for (int j = 0; j < N_X; j++) acc += q_product(mat_a[i*N_X + j], x_state[j]);
            for (int j = 0; j < N_U; j++) acc += q_product(mat_b[i*N_U + j], u_vec[j]);
            x_rate[i] = clip32(acc);
        end
        // Outputs use the state from before this step.
        for (int i = 0; i < N_Y; i++) begin
            acc = 0;
            for (int j = 0; j < N_X; j++) acc += q_product(mat_c[i*N_X + j], x_state[j]);
            for (int j = 0; j < N_U; j++) acc += q_product(mat_d[i*N_U + j], u_vec[j]);
            elem.value = clip32(acc);
            if (typed) elem.value = (i == 0) ? typed_y0 : typed_y1;
            elem.index = YIDX_W'(i);
            elem.last  = (i == N_Y - 1);
            pending_y.push_back(elem);
        end
        for (int i = 0; i < N_X; i++)
            x_state[i] = clip32(longint'(x_state[i]) + q_product(x_rate[i], longint'(rq.dt)));
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Mostly values within +/-2.0, some full-range, some corner values.
    function automatic logic signed [DATA_W-1:0] pick_q();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 12) return $urandom;
        if (r < 18) begin
            case ($urandom_range(0, 3))
                0: return Q_MAX;
                1: return Q_MIN;
                2: return ZERO;
                default: return M1;
            endcase
        end
        return int'($urandom_range(0, 262144)) - 131072;
    endfunction

    function automatic logic [DT_W-1:0] pick_dt();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8) return DT_W'($urandom_range(0, 32'h7fff_ffff));
        if (r < 14) return ($urandom_range(0, 1) != 0) ? DT_MAX : DT_ZERO;
        return DT_W'($urandom_range(0, 16384));
    endfunction

    function automatic t_request pick_request();
        t_request rq;
        int row_n, col_n;
        rq.req_type = ($urandom_range(0, 99) < 55) ? REQ_STEP : REQ_LOAD;
        rq.sel = t_mat_sel'($urandom_range(0, 3));
        row_n = (rq.sel == MAT_A || rq.sel == MAT_B) ? N_X : N_Y;
        col_n = (rq.sel == MAT_A || rq.sel == MAT_C) ? N_X : N_U;
        // Keep most writes inside the matrix so the dynamics keep changing.
        if ($urandom_range(0, 9) < 8) begin
            rq.row = RC_W'($urandom_range(0, row_n - 1));
            rq.col = RC_W'($urandom_range(0, col_n - 1));
        end else begin
            rq.row = RC_W'($urandom_range(0, 7));
            rq.col = RC_W'($urandom_range(0, 7));
        end
        rq.coef = pick_q();
        rq.u0 = pick_q();
        rq.u1 = pick_q();
        rq.u2 = pick_q();
        rq.u3 = pick_q();
        rq.dt = pick_dt();
        return rq;
    endfunction

    // Present one request at a falling edge, hold it until accepted, and
    // return at the next falling edge with valid still high.
    task automatic send_request(input t_request rq, input logic typed,
            input logic signed [DATA_W-1:0] typed_y0,
            input logic signed [DATA_W-1:0] typed_y1, input bit calm);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap != 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_req_type   = rq.req_type;
        i_matrix_sel = rq.sel;
        i_row        = rq.row;
        i_col        = rq.col;
        i_coef_value = rq.coef;
        i_u0         = rq.u0;
        i_u1         = rq.u1;
        i_u2         = rq.u2;
        i_u3         = rq.u3;
        i_step_dt    = rq.dt;
        i_in_valid   = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        euler_step_predict(rq, typed, typed_y0, typed_y1);
        @(negedge i_clk);
    endtask

    // Output side: random stalls, with quiet stretches where ready stays up.
    always @(negedge i_clk) begin
        cycle_cnt++;
        if (out_stall != 0) begin
            i_out_ready = 1'b0;
            out_stall--;
        end else begin
            i_out_ready = 1'b1;
            if (cycle_cnt[11:10] != 2'd0 && $urandom_range(0, 3) == 0)
                out_stall = pick_gap();
        end
    end

    // Check each output element against the oldest pending expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_checked++;
            if (pending_y.size() == 0) begin
                $error("output element with no step pending: y_index %0d y_value %0d",
                       o_y_index, o_y_value);
                n_errors++;
            end else begin
                want_y = pending_y.pop_front();
                if (o_y_value !== want_y.value) begin
                    $error("y_value: expected %0d, got %0d", want_y.value, o_y_value);
                    n_errors++;
                end
                if (o_y_index !== want_y.index) begin
                    $error("y_index: expected %0d, got %0d", want_y.index, o_y_index);
                    n_errors++;
                end
                if (o_last !== want_y.last) begin
                    $error("last: expected %0b, got %0b", want_y.last, o_last);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog: end the run if neither channel moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        t_request rq;
        // Hold every input at a known value from time zero.
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_out_ready  = 1'b0;
        i_req_type   = REQ_LOAD;
        i_matrix_sel = MAT_A;
        i_row        = '0;
        i_col        = '0;
        i_coef_value = '0;
        i_u0         = '0;
        i_u1         = '0;
        i_u2         = '0;
        i_u3         = '0;
        i_step_dt    = '0;
        for (int i = 0; i < N_X; i++) x_state[i] = '0;
        for (int i = 0; i < N_X*N_X; i++) mat_a[i] = '0;
        for (int i = 0; i < N_X*N_U; i++) mat_b[i] = '0;
        for (int i = 0; i < N_Y*N_X; i++) mat_c[i] = '0;
        for (int i = 0; i < N_Y*N_U; i++) mat_d[i] = '0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Walk the directed table.
        for (int k = 0; k < N_DIRECTED; k++)
            send_request(DIRECTED_ROWS[k].rq, DIRECTED_ROWS[k].typed,
                         DIRECTED_ROWS[k].y0, DIRECTED_ROWS[k].y1, 1'b0);

        // Random requests; every third stretch of 200 runs without gaps.
        for (int k = 0; k < RANDOM_REQUESTS; k++) begin
            rq = pick_request();
            send_request(rq, PRED, ZERO, ZERO, ((k / 200) % 3) == 2);
        end
        i_in_valid = 1'b0;

        // Drain, then give the block time to emit anything it should not.
        while (pending_y.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Ran %0d steps and %0d coefficient loads (%0d of them outside the matrix).",
                 n_steps, n_loads, n_dropped);
        $display("Compared %0d output elements, %0d mismatches.", n_checked, n_errors);
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
